@@ src/c8_pkg.sv @@
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants for the CHIP-8 instruction core
// Holds the sequencer states, the shared ALU codes and the font table.
// ----------------------------------------------------------------------------
package c8_pkg;

    localparam int ADDR_W     = 12;
    localparam int MEM_BYTES  = 4096;
    localparam int SCREEN_W   = 64;
    localparam int SCREEN_H   = 32;
    localparam int PIX_COUNT  = SCREEN_W * SCREEN_H;
    localparam int FONT_BYTES = 80;
    localparam int WORD_W     = 32;
    localparam int FRAME_WORDS = PIX_COUNT / WORD_W;

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    // host op selector codes
    localparam logic [2:0] OP_STEP     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_READ_MEM = 3'd2;
    localparam logic [2:0] OP_READ_REG = 3'd3;
    localparam logic [2:0] OP_READ_PIX = 3'd4;

    // opcode groups
    localparam logic [3:0] OPG_SYS    = 4'h0;
    localparam logic [3:0] OPG_JUMP   = 4'h1;
    localparam logic [3:0] OPG_SKEQI  = 4'h3;
    localparam logic [3:0] OPG_SKNEI  = 4'h4;
    localparam logic [3:0] OPG_SKEQR  = 4'h5;
    localparam logic [3:0] OPG_SETI   = 4'h6;
    localparam logic [3:0] OPG_ADDI   = 4'h7;
    localparam logic [3:0] OPG_ALU    = 4'h8;
    localparam logic [3:0] OPG_SKNER  = 4'h9;
    localparam logic [3:0] OPG_SETIDX = 4'hA;
    localparam logic [3:0] OPG_JUMPV0 = 4'hB;
    localparam logic [3:0] OPG_RAND   = 4'hC;
    localparam logic [3:0] OPG_DRAW   = 4'hD;

    // 8xyn sub-ops
    localparam logic [3:0] SUB_MOV = 4'h0;
    localparam logic [3:0] SUB_OR  = 4'h1;
    localparam logic [3:0] SUB_AND = 4'h2;
    localparam logic [3:0] SUB_XOR = 4'h3;
    localparam logic [3:0] SUB_ADD = 4'h4;
    localparam logic [3:0] SUB_SUB = 4'h5;

    localparam logic [7:0] NN_CLS   = 8'hE0;
    localparam logic [3:0] FLAG_REG = 4'hF;

    typedef enum logic [2:0] {
        ALU_PASS_B,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD8,
        ALU_SUB8,
        ALU_EQ,
        ALU_ADD12
    } alu_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] value;
        logic              flag;
    } alu_res_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM_WAIT,
        ST_REG_WAIT,
        ST_PIX_WAIT,
        ST_FETCH_LO,
        ST_FETCH_WAIT,
        ST_READ_X,
        ST_READ_Y,
        ST_EXEC,
        ST_WRITE_F,
        ST_NEXT_PC,
        ST_ROW_READ,
        ST_ROW_WAIT,
        ST_PIX,
        ST_PIX_WRITE,
        ST_DONE
    } state_t;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // reset content of program memory
    function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < ADDR_W'(FONT_BYTES))
        begin
            b = FONT[a[6:0]];
        end
        return b;
    endfunction

endpackage

@@ src/c8_alu.sv @@
// ----------------------------------------------------------------------------
// c8_alu: shared arithmetic and compare unit
// One 8-bit logic/add/sub/compare path and one 12-bit address adder.
// ----------------------------------------------------------------------------
module c8_alu (
    input  c8_pkg::alu_op_t                alu_op,
    input  logic [c8_pkg::ADDR_W-1:0]      a,
    input  logic [c8_pkg::ADDR_W-1:0]      b,
    output c8_pkg::alu_res_t               res
);

    logic [8:0] sum8;
    logic [7:0] diff8;

    assign sum8  = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    assign diff8 = a[7:0] - b[7:0];

    // operation select
    always_comb
    begin
        res.value = '0;
        res.flag  = 1'b0;
        unique case (alu_op)
            c8_pkg::ALU_PASS_B: res.value = b;
            c8_pkg::ALU_OR:     res.value = {4'h0, a[7:0] | b[7:0]};
            c8_pkg::ALU_AND:    res.value = {4'h0, a[7:0] & b[7:0]};
            c8_pkg::ALU_XOR:    res.value = {4'h0, a[7:0] ^ b[7:0]};
            c8_pkg::ALU_ADD8:
            begin
                res.value = {4'h0, sum8[7:0]};
                res.flag  = sum8[8];
            end
            c8_pkg::ALU_SUB8:
            begin
                res.value = {4'h0, diff8};
                res.flag  = a[7:0] > b[7:0];
            end
            c8_pkg::ALU_EQ:     res.flag  = a[7:0] == b[7:0];
            c8_pkg::ALU_ADD12:  res.value = a + b;
            default:            res.value = b;
        endcase
    end

endmodule

@@ src/chip8_instruction_core.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_core: partial CHIP-8 interpreter core
// Steps one instruction per item, and gives host access to memory,
// V registers and the frame buffer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries op, addr, wdata and
// rand_byte; the output channel (out_valid/out_ready) returns pc_now,
// opcode_done, read_data and collision, one result per item.
// One item is worked at a time under a sequencer around one shared ALU.
// A draw step takes longer with each sprite row and each pixel set on screen,
// through the row fetch and per-pixel read-modify-write of the frame memory.
// in_ready is high only in idle; a finished result sits in the output
// register, so the next item can be taken while it waits. If the receiver
// stalls with a result still held, the next result waits in the sequencer.
// After reset the program memory is loaded by a pass over all 4096 bytes
// (font glyphs, then zeros) during which in_ready stays low. V registers
// and the frame buffer read as zero after reset through valid bits.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [11:0] addr,
    input  logic [7:0]  wdata,
    input  logic [7:0]  rand_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pc_now,
    output logic [15:0] opcode_done,
    output logic [7:0]  read_data,
    output logic        collision
);

    localparam int AW = c8_pkg::ADDR_W;
    localparam int WW = c8_pkg::WORD_W;
    localparam int FW = $clog2(c8_pkg::FRAME_WORDS);
    localparam int BW = $clog2(c8_pkg::WORD_W);
    localparam int PW = $clog2(c8_pkg::PIX_COUNT);

    c8_pkg::state_t state_reg, state_next;

    // memories
    logic [7:0]    prog_mem [c8_pkg::MEM_BYTES];
    logic [7:0]    vreg_mem [16];
    logic [WW-1:0] frame_mem [c8_pkg::FRAME_WORDS];
    logic [15:0]   vvalid_reg;
    logic [c8_pkg::FRAME_WORDS-1:0] fvalid_reg;

    logic [7:0]    mem_q;
    logic [7:0]    vmem_q;
    logic          vvalid_q;
    logic [WW-1:0] fmem_q;
    logic          fvalid_q;

    // memory port controls
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic          v_we;
    logic [3:0]    v_waddr, v_raddr;
    logic [7:0]    v_wdata;
    logic          f_we;
    logic [FW-1:0] f_raddr;
    logic [WW-1:0] f_wdata;
    logic          f_clear;

    // datapath registers
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] pc_reg, idx_reg, addr_reg;
    logic [7:0]    rand_reg, hi_reg, a_reg, b_reg, bits_reg, rd_reg;
    logic [15:0]   opc_reg;
    logic          flag_reg, hit_reg;
    logic [3:0]    row_reg;
    logic [2:0]    col_reg;
    logic [8:0]    ycoord_reg;
    logic [PW-1:0] pos_reg;

    logic          out_valid_reg;
    logic [AW-1:0] pc_now_reg;
    logic [15:0]   opcode_done_reg;
    logic [7:0]    read_data_reg;
    logic          collision_reg;

    // shared unit
    c8_pkg::alu_op_t  alu_op;
    logic [AW-1:0]    alu_a, alu_b;
    c8_pkg::alu_res_t alu_res;

    c8_alu u_alu (
        .alu_op (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res)
    );

    logic          accept;
    logic [15:0]   fetched;
    logic [3:0]    grp, sub_op;
    logic [7:0]    nn;
    logic [AW-1:0] nnn;
    logic [7:0]    vq;
    logic [WW-1:0] fword;
    logic [14:0]   pos;
    logic          pix_on;
    logic          last_col, last_row;
    logic          hit_new;
    logic          skip;
    logic          out_free;

    assign in_ready = (state_reg == c8_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fetched  = {hi_reg, mem_q};
    assign grp      = opc_reg[15:12];
    assign sub_op   = opc_reg[3:0];
    assign nn       = opc_reg[7:0];
    assign nnn      = opc_reg[11:0];
    assign vq       = vvalid_q ? vmem_q : 8'h00;
    assign fword    = fvalid_q ? fmem_q : '0;
    assign out_free = !out_valid_reg || out_ready;

    // draw pixel position and loop ends
    assign pos      = {ycoord_reg, 6'b0} + 15'({1'b0, a_reg} + {6'b0, col_reg});
    assign pix_on   = bits_reg[3'd7 - col_reg] && (pos[14:PW] == '0);
    assign last_col = (col_reg == 3'd7);
    assign last_row = (({1'b0, row_reg} + 5'd1) == {1'b0, sub_op});
    assign hit_new  = hit_reg | fword[pos_reg[BW-1:0]];

    // skip condition from compare flag
    always_comb
    begin
        unique case (grp)
            c8_pkg::OPG_SKEQI, c8_pkg::OPG_SKEQR: skip = flag_reg;
            c8_pkg::OPG_SKNEI, c8_pkg::OPG_SKNER: skip = !flag_reg;
            default:                              skip = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr;
        mem_wdata  = wdata;
        mem_raddr  = pc_reg;
        v_we       = 1'b0;
        v_waddr    = opc_reg[11:8];
        v_wdata    = alu_res.value[7:0];
        v_raddr    = fetched[11:8];
        f_we       = 1'b0;
        f_raddr    = pos[PW-1:BW];
        f_wdata    = fword ^ (WW'(1) << pos_reg[BW-1:0]);
        f_clear    = 1'b0;
        alu_op     = c8_pkg::ALU_ADD12;
        alu_a      = pc_reg;
        alu_b      = 12'd1;
        unique case (state_reg)
            c8_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = c8_pkg::init_byte(clr_cnt_reg);
                if (clr_cnt_reg == '1)
                begin
                    state_next = c8_pkg::ST_IDLE;
                end
            end
            c8_pkg::ST_IDLE:
            begin
                v_raddr = addr[3:0];
                f_raddr = addr[PW-1:BW];
                if (op == c8_pkg::OP_READ_MEM)
                begin
                    mem_raddr = addr;
                end
                if (accept)
                begin
                    priority case (op)
                        c8_pkg::OP_STEP:     state_next = c8_pkg::ST_FETCH_LO;
                        c8_pkg::OP_WRITE:
                        begin
                            mem_we     = 1'b1;
                            state_next = c8_pkg::ST_DONE;
                        end
                        c8_pkg::OP_READ_MEM: state_next = c8_pkg::ST_MEM_WAIT;
                        c8_pkg::OP_READ_REG: state_next = c8_pkg::ST_REG_WAIT;
                        c8_pkg::OP_READ_PIX: state_next = c8_pkg::ST_PIX_WAIT;
                        default:             state_next = c8_pkg::ST_DONE;
                    endcase
                end
            end
            c8_pkg::ST_MEM_WAIT, c8_pkg::ST_REG_WAIT, c8_pkg::ST_PIX_WAIT:
            begin
                state_next = c8_pkg::ST_DONE;
            end
            c8_pkg::ST_FETCH_LO:
            begin
                mem_raddr  = alu_res.value;
                state_next = c8_pkg::ST_FETCH_WAIT;
            end
            c8_pkg::ST_FETCH_WAIT:
            begin
                // jump plus V0 reads V0 in place of Vx
                if (fetched[15:12] == c8_pkg::OPG_JUMPV0)
                begin
                    v_raddr = 4'h0;
                end
                state_next = c8_pkg::ST_READ_X;
            end
            c8_pkg::ST_READ_X:
            begin
                v_raddr    = opc_reg[7:4];
                state_next = c8_pkg::ST_READ_Y;
            end
            c8_pkg::ST_READ_Y:
            begin
                state_next = c8_pkg::ST_EXEC;
            end
            c8_pkg::ST_EXEC:
            begin
                alu_a      = {4'h0, a_reg};
                alu_b      = {4'h0, nn};
                alu_op     = c8_pkg::ALU_PASS_B;
                state_next = c8_pkg::ST_NEXT_PC;
                unique case (grp)
                    c8_pkg::OPG_SYS:
                    begin
                        f_clear = (nn == c8_pkg::NN_CLS);
                    end
                    c8_pkg::OPG_SKEQI, c8_pkg::OPG_SKNEI:
                    begin
                        alu_op = c8_pkg::ALU_EQ;
                    end
                    c8_pkg::OPG_SKEQR, c8_pkg::OPG_SKNER:
                    begin
                        alu_op = c8_pkg::ALU_EQ;
                        alu_b  = {4'h0, b_reg};
                    end
                    c8_pkg::OPG_SETI:
                    begin
                        v_we = 1'b1;
                    end
                    c8_pkg::OPG_ADDI:
                    begin
                        alu_op = c8_pkg::ALU_ADD8;
                        v_we   = 1'b1;
                    end
                    c8_pkg::OPG_ALU:
                    begin
                        alu_b = {4'h0, b_reg};
                        v_we  = 1'b1;
                        unique case (sub_op)
                            c8_pkg::SUB_MOV: alu_op = c8_pkg::ALU_PASS_B;
                            c8_pkg::SUB_OR:  alu_op = c8_pkg::ALU_OR;
                            c8_pkg::SUB_AND: alu_op = c8_pkg::ALU_AND;
                            c8_pkg::SUB_XOR: alu_op = c8_pkg::ALU_XOR;
                            c8_pkg::SUB_ADD:
                            begin
                                alu_op     = c8_pkg::ALU_ADD8;
                                state_next = c8_pkg::ST_WRITE_F;
                            end
                            c8_pkg::SUB_SUB:
                            begin
                                alu_op     = c8_pkg::ALU_SUB8;
                                state_next = c8_pkg::ST_WRITE_F;
                            end
                            default:         v_we = 1'b0;
                        endcase
                    end
                    c8_pkg::OPG_RAND:
                    begin
                        alu_op = c8_pkg::ALU_AND;
                        alu_a  = {4'h0, rand_reg};
                        v_we   = 1'b1;
                    end
                    c8_pkg::OPG_DRAW:
                    begin
                        if (sub_op == 4'h0)
                        begin
                            state_next = c8_pkg::ST_WRITE_F;
                        end
                        else
                        begin
                            state_next = c8_pkg::ST_ROW_READ;
                        end
                    end
                    default: ;
                endcase
            end
            c8_pkg::ST_WRITE_F:
            begin
                v_we       = 1'b1;
                v_waddr    = c8_pkg::FLAG_REG;
                v_wdata    = {7'b0, flag_reg};
                state_next = c8_pkg::ST_NEXT_PC;
            end
            c8_pkg::ST_NEXT_PC:
            begin
                if (grp == c8_pkg::OPG_JUMP)
                begin
                    alu_op = c8_pkg::ALU_PASS_B;
                    alu_b  = nnn;
                end
                else if (grp == c8_pkg::OPG_JUMPV0)
                begin
                    alu_a = {4'h0, a_reg};
                    alu_b = nnn;
                end
                else
                begin
                    alu_b = skip ? 12'd4 : 12'd2;
                end
                state_next = c8_pkg::ST_DONE;
            end
            c8_pkg::ST_ROW_READ:
            begin
                alu_a      = idx_reg;
                alu_b      = {8'h00, row_reg};
                mem_raddr  = alu_res.value;
                state_next = c8_pkg::ST_ROW_WAIT;
            end
            c8_pkg::ST_ROW_WAIT:
            begin
                state_next = c8_pkg::ST_PIX;
            end
            c8_pkg::ST_PIX, c8_pkg::ST_PIX_WRITE:
            begin
                if (state_reg == c8_pkg::ST_PIX_WRITE)
                begin
                    f_we = 1'b1;
                end
                if (state_reg == c8_pkg::ST_PIX && pix_on)
                begin
                    state_next = c8_pkg::ST_PIX_WRITE;
                end
                else if (!last_col)
                begin
                    state_next = c8_pkg::ST_PIX;
                end
                else if (last_row)
                begin
                    state_next = c8_pkg::ST_WRITE_F;
                end
                else
                begin
                    state_next = c8_pkg::ST_ROW_READ;
                end
            end
            c8_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = c8_pkg::ST_IDLE;
                end
            end
            default: state_next = c8_pkg::ST_IDLE;
        endcase
    end

    // program memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prog_mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= prog_mem[mem_raddr];
    end

    // V register file
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vreg_mem[v_waddr] <= v_wdata;
        end
        vmem_q <= vreg_mem[v_raddr];
    end

    // frame buffer, 32 pixels per word
    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            frame_mem[pos_reg[PW-1:BW]] <= f_wdata;
        end
        fmem_q <= frame_mem[f_raddr];
    end

    // valid bits for V registers and frame words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vvalid_reg <= '0;
            fvalid_reg <= '0;
            vvalid_q   <= 1'b0;
            fvalid_q   <= 1'b0;
        end
        else
        begin
            vvalid_q <= vvalid_reg[v_raddr];
            fvalid_q <= fvalid_reg[f_raddr];
            if (v_we)
            begin
                vvalid_reg[v_waddr] <= 1'b1;
            end
            if (f_clear)
            begin
                fvalid_reg <= '0;
            end
            else if (f_we)
            begin
                fvalid_reg[pos_reg[PW-1:BW]] <= 1'b1;
            end
        end
    end

    // architectural control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            pc_reg      <= c8_pkg::PC_RESET;
            idx_reg     <= '0;
        end
        else
        begin
            if (state_reg == c8_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 12'd1;
            end
            if (state_reg == c8_pkg::ST_NEXT_PC)
            begin
                pc_reg <= alu_res.value;
            end
            if (state_reg == c8_pkg::ST_EXEC && grp == c8_pkg::OPG_SETIDX)
            begin
                idx_reg <= nnn;
            end
        end
    end

    // item working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            c8_pkg::ST_IDLE:
            begin
                addr_reg <= addr;
                rand_reg <= rand_byte;
                opc_reg  <= '0;
                rd_reg   <= '0;
                hit_reg  <= 1'b0;
            end
            c8_pkg::ST_MEM_WAIT: rd_reg <= mem_q;
            c8_pkg::ST_REG_WAIT: rd_reg <= vq;
            c8_pkg::ST_PIX_WAIT: rd_reg <= {7'b0, fword[addr_reg[BW-1:0]]};
            c8_pkg::ST_FETCH_LO: hi_reg <= mem_q;
            c8_pkg::ST_FETCH_WAIT: opc_reg <= fetched;
            c8_pkg::ST_READ_X:   a_reg <= vq;
            c8_pkg::ST_READ_Y:   b_reg <= vq;
            c8_pkg::ST_EXEC:
            begin
                // a draw starts with the flag cleared
                flag_reg <= (grp == c8_pkg::OPG_DRAW) ? 1'b0 : alu_res.flag;
                row_reg  <= '0;
            end
            c8_pkg::ST_ROW_WAIT:
            begin
                bits_reg   <= mem_q;
                col_reg    <= '0;
                ycoord_reg <= {1'b0, b_reg} + {5'b0, row_reg};
            end
            c8_pkg::ST_PIX, c8_pkg::ST_PIX_WRITE:
            begin
                if (state_reg == c8_pkg::ST_PIX_WRITE)
                begin
                    hit_reg  <= hit_new;
                    flag_reg <= hit_new;
                end
                else
                begin
                    pos_reg <= pos[PW-1:0];
                end
                if (state_reg == c8_pkg::ST_PIX_WRITE || !pix_on)
                begin
                    col_reg <= col_reg + 3'd1;
                    if (last_col)
                    begin
                        row_reg <= row_reg + 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == c8_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == c8_pkg::ST_DONE && out_free)
        begin
            pc_now_reg      <= pc_reg;
            opcode_done_reg <= opc_reg;
            read_data_reg   <= rd_reg;
            collision_reg   <= hit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pc_now      = pc_now_reg;
    assign opcode_done = opcode_done_reg;
    assign read_data   = read_data_reg;
    assign collision   = collision_reg;

endmodule

@@ src/c8_checker.sv @@
// ----------------------------------------------------------------------------
// c8_checker: port-level checks for the CHIP-8 instruction core
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module c8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] opcode_done,
    input logic [7:0]  read_data,
    input logic        collision
);

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one item at a time: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // collision comes only from a draw step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collision |-> opcode_done[15:12] == 4'hD)
        else $error("collision without draw");

    // read data only on host reads, never with an executed opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data != 8'h00 |-> opcode_done == 16'h0000)
        else $error("read data on a step result");

endmodule

bind chip8_instruction_core c8_checker u_c8_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .opcode_done (opcode_done),
    .read_data   (read_data),
    .collision   (collision)
);

@@ sim/chip8_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_checker: result predictor and scoreboard for the CHIP-8 core
// Keeps its own image of memory, V registers, pc, index and frame, works out
// the result of every accepted item and compares the returned results in order.
// ----------------------------------------------------------------------------
module chip8_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [11:0] addr,
    input  logic [7:0]  wdata,
    input  logic [7:0]  rand_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] pc_now,
    input  logic [15:0] opcode_done,
    input  logic [7:0]  read_data,
    input  logic        collision,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          hit_count,
    output logic [11:0] pc_model
);

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opc;
        logic [7:0]  rd;
        logic        coll;
    } result_t;

    result_t     result_q[$];
    logic [7:0]  mem_img [c8_pkg::MEM_BYTES];
    logic [7:0]  vreg_img [16];
    logic        frame_img [c8_pkg::PIX_COUNT];
    logic [11:0] pc_img;
    logic [11:0] index_img;

    // power-up image of the core
    task automatic reset_image();
        for (int i = 0; i < c8_pkg::MEM_BYTES; i++)
        begin
            mem_img[i] = (i < c8_pkg::FONT_BYTES) ? c8_pkg::FONT[i] : 8'h00;
        end
        for (int i = 0; i < 16; i++)
        begin
            vreg_img[i] = 8'h00;
        end
        for (int i = 0; i < c8_pkg::PIX_COUNT; i++)
        begin
            frame_img[i] = 1'b0;
        end
        pc_img    = c8_pkg::PC_RESET;
        index_img = '0;
    endtask

    // xor a sprite into the frame, pixels past the last one are dropped
    task automatic draw_sprite(input logic [3:0] xr, input logic [3:0] yr,
                               input logic [3:0] height, output logic hit);
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] bits;
        int         pos;
        px  = vreg_img[xr];
        py  = vreg_img[yr];
        hit = 1'b0;
        vreg_img[c8_pkg::FLAG_REG] = 8'h00;
        for (int row = 0; row < height; row++)
        begin
            bits = mem_img[12'(index_img + row)];
            for (int col = 0; col < 8; col++)
            begin
                if (bits[7-col])
                begin
                    pos = (int'(py) + row) * c8_pkg::SCREEN_W + int'(px) + col;
                    if (pos < c8_pkg::PIX_COUNT)
                    begin
                        if (frame_img[pos])
                        begin
                            hit = 1'b1;
                        end
                        frame_img[pos] = !frame_img[pos];
                    end
                end
            end
        end
        vreg_img[c8_pkg::FLAG_REG] = {7'd0, hit};
    endtask

    // fetch and execute one opcode
    task automatic step_core(input logic [7:0] rnd, output logic [15:0] opc,
                             output logic hit);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [8:0]  sum;
        logic [11:0] next;
        opc  = {mem_img[pc_img], mem_img[12'(pc_img + 1)]};
        x    = opc[11:8];
        y    = opc[7:4];
        a    = vreg_img[x];
        b    = vreg_img[y];
        next = pc_img + 12'd2;
        hit  = 1'b0;
        case (opc[15:12])
            c8_pkg::OPG_SYS:
                if (opc[7:0] == c8_pkg::NN_CLS)
                begin
                    for (int i = 0; i < c8_pkg::PIX_COUNT; i++)
                    begin
                        frame_img[i] = 1'b0;
                    end
                end
            c8_pkg::OPG_JUMP:   next = opc[11:0];
            c8_pkg::OPG_SKEQI:  if (a == opc[7:0]) next = next + 12'd2;
            c8_pkg::OPG_SKNEI:  if (a != opc[7:0]) next = next + 12'd2;
            c8_pkg::OPG_SKEQR:  if (a == b) next = next + 12'd2;
            c8_pkg::OPG_SETI:   vreg_img[x] = opc[7:0];
            c8_pkg::OPG_ADDI:   vreg_img[x] = a + opc[7:0];
            c8_pkg::OPG_ALU:
                case (opc[3:0])
                    c8_pkg::SUB_MOV: vreg_img[x] = b;
                    c8_pkg::SUB_OR:  vreg_img[x] = a | b;
                    c8_pkg::SUB_AND: vreg_img[x] = a & b;
                    c8_pkg::SUB_XOR: vreg_img[x] = a ^ b;
                    c8_pkg::SUB_ADD:
                    begin
                        sum = {1'b0, a} + {1'b0, b};
                        vreg_img[x] = sum[7:0];
                        vreg_img[c8_pkg::FLAG_REG] = {7'd0, sum[8]};
                    end
                    c8_pkg::SUB_SUB:
                    begin
                        vreg_img[x] = a - b;
                        vreg_img[c8_pkg::FLAG_REG] = {7'd0, a > b};
                    end
                    default: ;
                endcase
            c8_pkg::OPG_SKNER:  if (a != b) next = next + 12'd2;
            c8_pkg::OPG_SETIDX: index_img = opc[11:0];
            c8_pkg::OPG_JUMPV0: next = 12'(vreg_img[0]) + opc[11:0];
            c8_pkg::OPG_RAND:   vreg_img[x] = rnd & opc[7:0];
            c8_pkg::OPG_DRAW:   draw_sprite(x, y, opc[3:0], hit);
            default: ;
        endcase
        pc_img = next;
    endtask

    // predict the result of one accepted item
    task automatic predict_result(output result_t res);
        logic [15:0] opc;
        logic        hit;
        res = '0;
        case (op)
            c8_pkg::OP_STEP:
            begin
                step_core(rand_byte, opc, hit);
                res.opc  = opc;
                res.coll = hit;
            end
            c8_pkg::OP_WRITE:    mem_img[addr] = wdata;
            c8_pkg::OP_READ_MEM: res.rd = mem_img[addr];
            c8_pkg::OP_READ_REG: res.rd = vreg_img[addr[3:0]];
            c8_pkg::OP_READ_PIX: res.rd = {7'd0, frame_img[addr[10:0]]};
            default: ;
        endcase
        res.pc = pc_img;
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        result_t res;
        result_t exp_res;
        if (!rst_n)
        begin
            reset_image();
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            hit_count  <= 0;
            pc_model   <= c8_pkg::PC_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_result(res);
                result_q.push_back(res);
                if (res.coll)
                begin
                    hit_count <= hit_count + 1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no item outstanding: pc_now %h", pc_now);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    checked <= checked + 1;
                    if (exp_res.pc != pc_now)
                    begin
                        $error("pc_now: expected %h, got %h", exp_res.pc, pc_now);
                    end
                    if (exp_res.opc != opcode_done)
                    begin
                        $error("opcode_done: expected %h, got %h", exp_res.opc,
                               opcode_done);
                    end
                    if (exp_res.rd != read_data)
                    begin
                        $error("read_data: expected %h, got %h", exp_res.rd,
                               read_data);
                    end
                    if (exp_res.coll != collision)
                    begin
                        $error("collision: expected %b, got %b", exp_res.coll,
                               collision);
                    end
                    if (exp_res != {pc_now, opcode_done, read_data, collision})
                    begin
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending  <= result_q.size();
            pc_model <= pc_img;
        end
    end

endmodule

@@ sim/tb_chip8_instruction_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core: testbench for the CHIP-8 instruction core
// Loads opcodes at the current pc through host writes and steps them, mixed
// with host reads, plain steps and stray ops, under random idling on both
// channels. The results are checked in chip8_checker.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_ITEMS   = 1050;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rand_byte;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] pc_now;
    logic [15:0] opcode_done;
    logic [7:0]  read_data;
    logic        collision;

    int          fail_count;
    int          pending;
    int          checked;
    int          hit_count;
    logic [11:0] pc_model;

    int          item_count;
    int          step_count;
    int          cycle_count;
    int          stall_left;
    bit          calm;

    chip8_instruction_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .addr        (addr),
        .wdata       (wdata),
        .rand_byte   (rand_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pc_now      (pc_now),
        .opcode_done (opcode_done),
        .read_data   (read_data),
        .collision   (collision)
    );

    chip8_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .addr        (addr),
        .wdata       (wdata),
        .rand_byte   (rand_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pc_now      (pc_now),
        .opcode_done (opcode_done),
        .read_data   (read_data),
        .collision   (collision),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .hit_count   (hit_count),
        .pc_model    (pc_model)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // hand one item to the core, with an optional idle burst first
    task automatic send_item(input logic [2:0] o, input logic [11:0] a,
                             input logic [7:0] d, input logic [7:0] r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        addr      <= a;
        wdata     <= d;
        rand_byte <= r;
        do @(posedge clk); while (!in_ready);
        item_count++;
        if (o == c8_pkg::OP_STEP)
        begin
            step_count++;
        end
    endtask

    // random host read of memory, register or pixel
    task automatic send_read();
        logic [2:0] o;
        o = c8_pkg::OP_READ_MEM + 3'($urandom_range(0, 2));
        send_item(o, 12'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // a read first lets the pc of the last step settle, then the opcode is
    // placed at pc and stepped
    task automatic run_opcode(input logic [15:0] opc);
        logic [11:0] at;
        send_read();
        at = pc_model;
        send_item(c8_pkg::OP_WRITE, at, opc[15:8], 8'($urandom));
        send_item(c8_pkg::OP_WRITE, at + 12'd1, opc[7:0], 8'($urandom));
        send_item(c8_pkg::OP_STEP, 12'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // random opcode from any of the sixteen groups, weighted toward implemented sub-ops
    function automatic logic [15:0] random_opcode();
        logic [15:0] opc;
        logic [3:0]  grp;
        opc = 16'($urandom);
        grp = 4'($urandom_range(0, 15));
        opc[15:12] = grp;
        case (grp)
            c8_pkg::OPG_SYS:
                case ($urandom_range(0, 2))
                    0: opc[11:0] = {4'h0, c8_pkg::NN_CLS};
                    1: opc[11:0] = 12'h0EE;
                    default: ;
                endcase
            c8_pkg::OPG_SKEQI, c8_pkg::OPG_SKNEI:
                if ($urandom_range(0, 1) == 0) opc[7:0] = 8'h00;
            c8_pkg::OPG_ALU:
                if ($urandom_range(0, 4) != 0) opc[3:0] = 4'($urandom_range(0, 5));
            c8_pkg::OPG_SETIDX:
                if ($urandom_range(0, 1) == 0) opc[11:0] = 12'($urandom_range(0, 79));
            default: ;
        endcase
        return opc;
    endfunction

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = c8_pkg::OP_STEP;
        addr       = '0;
        wdata      = '0;
        rand_byte  = '0;
        calm       = 1'b0;
        item_count = 0;
        step_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // stray ops and host access at the field extremes
        send_item(3'd5, 12'hFFF, 8'hFF, 8'hFF);
        send_item(3'd6, 12'h000, 8'h00, 8'h00);
        send_item(3'd7, 12'hFFF, 8'hFF, 8'hFF);
        send_item(c8_pkg::OP_WRITE, 12'hFFF, 8'hFF, 8'h00);
        send_item(c8_pkg::OP_READ_MEM, 12'hFFF, 8'h00, 8'h00);
        send_item(c8_pkg::OP_READ_MEM, 12'h000, 8'h00, 8'h00);
        send_item(c8_pkg::OP_READ_REG, 12'hFFF, 8'h00, 8'h00);
        send_item(c8_pkg::OP_READ_PIX, 12'hFFF, 8'h00, 8'h00);

        // alu ops, carry and borrow, skips
        run_opcode(16'h6AFF);
        run_opcode(16'h6B01);
        run_opcode(16'h8AB4);
        run_opcode(16'h8AB5);
        run_opcode(16'h8BA5);
        run_opcode(16'h7A01);
        run_opcode(16'h8AB1);
        run_opcode(16'h8AB2);
        run_opcode(16'h8AB3);
        run_opcode(16'h8AB0);
        run_opcode(16'h3A01);
        run_opcode(16'h4A00);
        run_opcode(16'h5AB0);
        run_opcode(16'h9AB0);
        // flag register as operand
        run_opcode(16'h6F80);
        run_opcode(16'h8FF4);
        // draws: glyph, redraw for collision, bottom-right edge, zero height
        run_opcode(16'h6000);
        run_opcode(16'hA000);
        run_opcode(16'hD005);
        run_opcode(16'hD005);
        run_opcode(16'h6E3F);
        run_opcode(16'h6D1F);
        run_opcode(16'hDED8);
        run_opcode(16'hD000);
        run_opcode(16'hC3AA);
        run_opcode(16'h00E0);
        // pc wrap past the top, then fetch straddling 0xfff
        run_opcode(16'h1FFE);
        run_opcode(16'h7001);
        run_opcode(16'hBFFE);
        run_opcode(16'hF00A);
        run_opcode(16'h1200);

        // random part
        while (item_count < RANDOM_ITEMS)
        begin
            if (item_count >= CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: send_item(c8_pkg::OP_STEP, 12'($urandom), 8'($urandom),
                             8'($urandom));
                1: send_item(c8_pkg::OP_WRITE, 12'($urandom), 8'($urandom),
                             8'($urandom));
                2:
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_item(3'($urandom_range(5, 7)), 12'($urandom),
                                  8'($urandom), 8'($urandom));
                    end
                    else
                    begin
                        send_read();
                    end
                default: run_opcode(random_opcode());
            endcase
        end
        in_valid <= 1'b0;

        // wait for the last results, then let the core settle
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d of them steps; %0d results checked",
                 item_count, step_count, checked);
        $display("%0d draw steps reported a collision", hit_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
